// ===== hw/rtl/bib_pkg.sv =====
// Shared constants, command codes and controller/datapath handshake structs
// for the bucket index builder. No dependencies.
package bib_pkg;

  localparam int KEY_BITS   = 12;
  localparam int DEPTH      = 1 << KEY_BITS;
  localparam int IDX_W      = KEY_BITS + 1;
  localparam int AK_W       = 13;
  localparam int CMP_W      = (AK_W > IDX_W) ? AK_W : IDX_W;
  localparam int DATA_W     = 32;
  localparam int CMD_W      = 3;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CMD_W-1:0] CMD_COUNT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BUILD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ZERO  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STORE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PRUNE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd5;
  localparam logic [CMD_W-1:0] CMD_QUERY = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_KEYS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_LIMIT  = 1'd1;

  localparam logic [AK_W-1:0]   ACTIVE_KEYS_RST = AK_W'(4096);
  localparam logic [DATA_W-1:0] SIZE_LIMIT_RST  = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // load the item and issue its table read
    logic exec;       // finish a point command and load the result
    logic walk_step;  // handle one key of a table walk
    logic init;       // post-reset clearing sweep is running
    logic finish;     // load the walk total as the result
  } dp_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_is_walk;  // offered item walks the table
    logic walk_done;   // walk index reached its end
    logic stage_busy;  // a read is still returning from the walk
    logic out_free;    // result register can take a new result
  } dp_sts_t;

endpackage

// ===== hw/rtl/bib_if.sv =====
// Valid/ready channel interfaces for input items and results.
// Depends on bib_pkg.
interface bib_in_if import bib_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [KEY_BITS-1:0] key;
  logic [DATA_W-1:0]   position;

  modport source (output valid, command, key, position, input ready);
  modport sink   (input valid, command, key, position, output ready);
endinterface

interface bib_out_if import bib_pkg::*;;
  logic              valid;
  logic              ready;
  logic              status;
  logic [DATA_W-1:0] store_address;
  logic [DATA_W-1:0] store_value;
  logic              store_valid;
  logic [DATA_W-1:0] key_offset;
  logic [DATA_W-1:0] key_count;
  logic [DATA_W-1:0] total;

  modport source (output valid, status, store_address, store_value, store_valid,
                  key_offset, key_count, total, input ready);
  modport sink   (input valid, status, store_address, store_value, store_valid,
                  key_offset, key_count, total, output ready);
endinterface

// ===== hw/rtl/bucket_index_builder_unit.sv =====
// Top level of the bucket index builder: controller plus datapath.
// Depends on bib_pkg, bib_if, bib_ctrl and bib_datapath.

// Keeps a 32-bit offset and a 32-bit count per key in two single-port-write
// memories and runs one command per beat, with exactly one result beat per
// command. After reset the block sweeps both memories to zero, one entry per
// cycle, and item_in.ready stays low until the sweep is done; the clear-all
// command runs the same sweep. Count, store, query, an out-of-range key and
// command seven go through the memory read issued at acceptance, then the
// write-back and result load. Build offsets, zero counts and prune walk keys
// 0..min(active_keys, 2^KEY_BITS)-1 at one key per cycle through the memory port.
// Results wait in an output register; the next item is taken once the controller
// is idle again. Configuration is written through cfg_we/cfg_index/cfg_data
// by the user only while no command is in flight; the block does not check this.
module bucket_index_builder_unit import bib_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  bib_in_if.sink               item_in,
  bib_out_if.source            result_out
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  bib_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_ready (item_in.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  bib_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_command        (item_in.command),
    .in_key            (item_in.key),
    .in_position       (item_in.position),
    .out_ready         (result_out.ready),
    .out_valid         (result_out.valid),
    .out_status        (result_out.status),
    .out_store_address (result_out.store_address),
    .out_store_value   (result_out.store_value),
    .out_store_valid   (result_out.store_valid),
    .out_key_offset    (result_out.key_offset),
    .out_key_count     (result_out.key_count),
    .out_total         (result_out.total),
    .ctl               (ctl),
    .sts               (sts)
  );

`ifndef SYNTH
  // Nothing is taken during the clearing sweep that follows reset.
  a_init_blocks: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !item_in.ready)
    else $error("item accepted during the post-reset clear");

  // One command at a time: no beat is taken in the cycle after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (item_in.valid && item_in.ready) |=> !item_in.ready)
    else $error("second beat accepted while a command is in flight");

  // A walk must have drained its read stage before a new item is taken.
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    item_in.ready |-> !sts.stage_busy)
    else $error("walk stage still busy while ready");

  // A rejected key never produces a scatter write.
  a_reject_no_store: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.status) |-> !result_out.store_valid)
    else $error("store write on a rejected key");
`endif

endmodule

// ===== hw/rtl/bib_ctrl.sv =====
// Controller state machine for the bucket index builder.
// Depends on bib_pkg; drives the datapath through dp_ctl_t.
module bib_ctrl import bib_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_ctl_t ctl
);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_WALK   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_INIT: begin
        ctl.init = 1'b1;
        if (sts.walk_done) begin
          state_next = ST_IDLE;
        end else begin
          ctl.walk_step = 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.accept = 1'b1;
          state_next = sts.in_is_walk ? ST_WALK : ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.out_free) begin
          ctl.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (sts.walk_done) begin
          state_next = ST_FINISH;
        end else begin
          ctl.walk_step = 1'b1;
        end
      end
      ST_FINISH: begin
        // The last read of the walk must land in the total first.
        if (!sts.stage_busy && sts.out_free) begin
          ctl.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

// ===== hw/rtl/bib_datapath.sv =====
// Datapath of the bucket index builder: configuration registers, the offset
// and count memories, the walk index and accumulator, and the result register.
// Depends on bib_pkg; steered by bib_ctrl through dp_ctl_t / dp_sts_t.
module bib_datapath import bib_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [KEY_BITS-1:0]  in_key,
  input  logic [DATA_W-1:0]    in_position,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_status,
  output logic [DATA_W-1:0]    out_store_address,
  output logic [DATA_W-1:0]    out_store_value,
  output logic                 out_store_valid,
  output logic [DATA_W-1:0]    out_key_offset,
  output logic [DATA_W-1:0]    out_key_count,
  output logic [DATA_W-1:0]    out_total,
  input  dp_ctl_t              ctl,
  output dp_sts_t              sts
);

  logic [AK_W-1:0]   active_keys;
  logic [DATA_W-1:0] size_limit;

  logic [DATA_W-1:0] offset_mem [DEPTH];
  logic [DATA_W-1:0] count_mem  [DEPTH];
  logic [DATA_W-1:0] rd_off;
  logic [DATA_W-1:0] rd_cnt;

  logic [CMD_W-1:0]    cmd;
  logic [KEY_BITS-1:0] key;
  logic [DATA_W-1:0]   pos;
  logic                bad;

  logic [IDX_W-1:0]    idx;
  logic [DATA_W-1:0]   acc;
  logic                s_valid;
  logic [KEY_BITS-1:0] s_idx;

  logic                in_needs_key;
  logic                in_bad;
  logic                full_sweep;
  logic                walk_read;
  logic                walk_zero;
  logic                walk_clear;
  logic                rd_en;
  logic [KEY_BITS-1:0] raddr;
  logic                cnt_we;
  logic [KEY_BITS-1:0] cnt_waddr;
  logic [DATA_W-1:0]   cnt_wdata;
  logic                off_we;
  logic [KEY_BITS-1:0] off_waddr;
  logic [DATA_W-1:0]   off_wdata;
  logic                over_limit;
  logic                load_result;
  logic                res_status;
  logic [DATA_W-1:0]   res_address;
  logic [DATA_W-1:0]   res_value;
  logic                res_store;
  logic [DATA_W-1:0]   res_offset;
  logic [DATA_W-1:0]   res_count;
  logic [DATA_W-1:0]   res_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_keys <= ACTIVE_KEYS_RST;
      size_limit  <= SIZE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_KEYS: active_keys <= cfg_data[AK_W-1:0];
        REG_SIZE_LIMIT:  size_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // A key is always below the table depth, so comparing against active_keys
  // alone also covers the clamp to the depth.
  assign in_needs_key = (in_command == CMD_COUNT) || (in_command == CMD_STORE) ||
                        (in_command == CMD_QUERY);
  assign in_bad = in_needs_key && (CMP_W'(in_key) >= CMP_W'(active_keys));

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd <= in_command;
      key <= in_key;
      pos <= in_position;
      bad <= in_bad;
    end
  end

  // Clear all sweeps the whole table; the other walks stop at the lower of active_keys and the table depth.
  assign full_sweep = ctl.init || (cmd == CMD_CLEAR);
  assign walk_read  = ctl.walk_step && !ctl.init &&
                      ((cmd == CMD_BUILD) || (cmd == CMD_PRUNE));
  assign walk_zero  = ctl.walk_step && !ctl.init && (cmd == CMD_ZERO);
  assign walk_clear = ctl.walk_step && full_sweep;

  assign sts.in_is_walk = (in_command == CMD_BUILD) || (in_command == CMD_ZERO) ||
                          (in_command == CMD_PRUNE) || (in_command == CMD_CLEAR);
  assign sts.walk_done  = idx[KEY_BITS] ||
                          (!full_sweep && (CMP_W'(idx) >= CMP_W'(active_keys)));
  assign sts.stage_busy = s_valid;
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      s_valid <= 1'b0;
    end else begin
      if (ctl.accept) begin
        idx <= '0;
      end else if (ctl.walk_step) begin
        idx <= idx + IDX_W'(1);
      end
      s_valid <= walk_read;
    end
  end

  always_ff @(posedge clk) begin
    if (walk_read) begin
      s_idx <= idx[KEY_BITS-1:0];
    end
  end

  assign over_limit = rd_cnt >= size_limit;

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      acc <= '0;
    end else if (s_valid) begin
      if (cmd == CMD_BUILD) begin
        acc <= acc + rd_cnt;
      end else if (over_limit) begin
        acc <= acc + DATA_W'(1);
      end
    end
  end

  assign rd_en = ctl.accept || walk_read;
  assign raddr = ctl.accept ? in_key : idx[KEY_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_off <= offset_mem[raddr];
      rd_cnt <= count_mem[raddr];
    end
  end

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = idx[KEY_BITS-1:0];
    cnt_wdata = '0;
    off_we    = 1'b0;
    off_waddr = idx[KEY_BITS-1:0];
    off_wdata = '0;
    priority if (ctl.exec) begin
      cnt_we    = !bad && ((cmd == CMD_COUNT) || (cmd == CMD_STORE));
      cnt_waddr = key;
      cnt_wdata = rd_cnt + DATA_W'(1);
    end else if (s_valid) begin
      cnt_we    = (cmd == CMD_PRUNE) && over_limit;
      cnt_waddr = s_idx;
      off_we    = (cmd == CMD_BUILD);
      off_waddr = s_idx;
      off_wdata = acc;
    end else if (walk_zero || walk_clear) begin
      cnt_we = 1'b1;
      off_we = walk_clear;
    end else begin
      cnt_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      count_mem[cnt_waddr] <= cnt_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (off_we) begin
      offset_mem[off_waddr] <= off_wdata;
    end
  end

  always_comb begin
    res_status  = 1'b0;
    res_address = '0;
    res_value   = '0;
    res_store   = 1'b0;
    res_offset  = '0;
    res_count   = '0;
    res_total   = '0;
    if (ctl.exec) begin
      res_status = bad;
      if (!bad && (cmd == CMD_STORE)) begin
        res_address = rd_off + rd_cnt;
        res_value   = pos;
        res_store   = 1'b1;
      end
      if (!bad && (cmd == CMD_QUERY)) begin
        res_offset = rd_off;
        res_count  = rd_cnt;
      end
    end else if ((cmd == CMD_BUILD) || (cmd == CMD_PRUNE)) begin
      res_total = acc;
    end
  end

  assign load_result = ctl.exec || ctl.finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      out_status        <= res_status;
      out_store_address <= res_address;
      out_store_value   <= res_value;
      out_store_valid   <= res_store;
      out_key_offset    <= res_offset;
      out_key_count     <= res_count;
      out_total         <= res_total;
    end
  end

endmodule
